// ----- sv/wav_hdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package wav_hdr_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW = FIFO_AW + 1;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM = 16'd1;
  localparam logic [31:0] FMT_MIN_SIZE = 32'd16;

  localparam int unsigned NUM_RATES = 11;
  localparam logic [31:0] RATE_LIST [NUM_RATES] = '{
    32'd8000, 32'd11025, 32'd12000, 32'd16000, 32'd22050, 32'd24000,
    32'd32000, 32'd44100, 32'd48000, 32'd64000, 32'd96000
  };

  typedef enum logic [1:0] {
    KIND_FORMAT = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_TAGS  = 4'd1,
    ST_FMT_SHORT = 4'd2,
    ST_NOT_PCM   = 4'd3,
    ST_MISSING   = 4'd4,
    ST_TRUNCATED = 4'd5,
    ST_CHANNELS  = 4'd6,
    ST_RATE      = 4'd7,
    ST_BITS      = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HDR  = 3'd1,
    PH_FMT  = 3'd2,
    PH_SKIP = 3'd3,
    PH_DATA = 3'd4,
    PH_DONE = 3'd5,
    PH_HALT = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       file_start;
    logic       file_end;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    status_e     status;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [15:0] sample_bits;
    logic [31:0] payload_size;
    logic [7:0]  payload_byte;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic v0;
    logic v1;
  } push_t;

  function automatic logic rate_ok(input logic [31:0] r);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_RATES; i++) begin
      if (RATE_LIST[i] == r) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

// ----- sv/wav_pcm_header_parser_top.sv -----
// WAV PCM header parser. Takes one file byte per clock unless stalled, checks
// the RIFF/WAVE tags, walks the chunks to the fmt and data chunks, and emits
// one format record followed by the data bytes (last set on the final one),
// or one error record; after an error or a finished file, bytes are dropped
// until an item with file_start. Throughput is one byte per cycle when the
// input does not stall: the byte is registered in the input stage, parsed by
// combinational logic and written into a four-entry result queue. An item that
// yields a record plus an error pushes both records into the queue, and input
// stalls while a byte waits in the input register and the queue has room for
// fewer than two records.
`timescale 1ns / 1ps
`default_nettype none

module wav_pcm_header_parser_top (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_we_i,
  input  wire                    cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  input  wav_hdr_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output wav_hdr_pkg::out_item_t out_item_o
);

  logic                   check_q;
  logic                   s1_valid_q, s1_valid_d;
  wav_hdr_pkg::in_item_t  s1_item_q;
  logic                   room;
  logic                   consume;
  logic                   accept;
  wav_hdr_pkg::push_t     push;
  wav_hdr_pkg::out_item_t rec0, rec1;

  assign consume    = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;
  assign s1_valid_d = accept || (s1_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      check_q    <= 1'b1;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (cfg_we_i) begin
        check_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_item_i;
    end
  end

  wav_hdr_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (consume),
    .item_i         (s1_item_q),
    .check_format_i (check_q),
    .push_o         (push),
    .rec0_o         (rec0),
    .rec1_o         (rec1)
  );

  wav_hdr_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .rec0_i      (rec0),
    .rec1_i      (rec1),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // records only come from a byte being parsed
  a_push_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.v0 || push.v1) |-> consume)
    else $error("record pushed without a parsed item");

  // a second record is always an error trailing a format or data record
  a_second_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.v1 |-> (push.v0 && rec1.kind == wav_hdr_pkg::KIND_ERROR &&
                 rec0.kind != wav_hdr_pkg::KIND_ERROR))
    else $error("bad record pairing");

  // a waiting byte is held until the parser takes it
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !consume) |=> (s1_valid_q && $stable(s1_item_q)))
    else $error("input stage lost a waiting item");
`endif

endmodule

`default_nettype wire

// ----- sv/wav_hdr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wav_hdr_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wav_hdr_pkg::push_t     push_i,
  input  wav_hdr_pkg::out_item_t rec0_i,
  input  wav_hdr_pkg::out_item_t rec1_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output wav_hdr_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = wav_hdr_pkg::FIFO_AW;
  localparam int unsigned CW = wav_hdr_pkg::FIFO_CW;
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(wav_hdr_pkg::FIFO_DEPTH - 2);

  wav_hdr_pkg::out_item_t mem_q [wav_hdr_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] wr_next;
  logic          pop;

  assign out_valid_o = (count_q != '0);
  assign out_item_o  = mem_q[rd_ptr_q];
  assign room_o      = (count_q <= ROOM_LIMIT);
  assign pop         = out_valid_o && !out_stall_i;
  assign wr_next     = wr_ptr_q + AW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + {{(AW-1){1'b0}}, push_i.v0} + {{(AW-1){1'b0}}, push_i.v1};
    rd_ptr_d = rd_ptr_q + {{(AW-1){1'b0}}, pop};
    count_d  = count_q + {{(CW-1){1'b0}}, push_i.v0} + {{(CW-1){1'b0}}, push_i.v1}
               - {{(CW-1){1'b0}}, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_ptr_q] <= rec0_i;
    end
    if (push_i.v1) begin
      mem_q[wr_next] <= rec1_i;
    end
  end

endmodule

`default_nettype wire

// ----- sv/wav_hdr_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module wav_hdr_parser (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    item_valid_i,
  input  wav_hdr_pkg::in_item_t  item_i,
  input  wire                    check_format_i,
  output wav_hdr_pkg::push_t     push_o,
  output wav_hdr_pkg::out_item_t rec0_o,
  output wav_hdr_pkg::out_item_t rec1_o
);

  wav_hdr_pkg::phase_e phase_q, phase_d;
  logic [4:0]  bc_q, bc_d;
  logic [31:0] aw_q, aw_d;
  logic [31:0] tag_q, tag_d;
  logic [32:0] skip_q, skip_d;
  logic        fseen_q, fseen_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] drem_q, drem_d;

  logic                   norm_v, err_v;
  wav_hdr_pkg::out_item_t norm_rec, err_rec;
  wav_hdr_pkg::status_e   err_st;
  logic [7:0]             b;
  logic [3:0]             p;
  logic [32:0]            cnt;

  always_comb begin
    phase_d  = phase_q;
    bc_d     = bc_q;
    aw_d     = aw_q;
    tag_d    = tag_q;
    skip_d   = skip_q;
    fseen_d  = fseen_q;
    ftag_d   = ftag_q;
    ch_d     = ch_q;
    rate_d   = rate_q;
    bits_d   = bits_q;
    drem_d   = drem_q;
    norm_v   = 1'b0;
    norm_rec = '0;
    err_v    = 1'b0;
    err_st   = wav_hdr_pkg::ST_OK;
    b        = item_i.stream_byte;
    p        = '0;
    cnt      = '0;

    if (item_i.file_start) begin
      phase_d = wav_hdr_pkg::PH_RIFF;
      bc_d    = '0;
      aw_d    = '0;
      tag_d   = '0;
      skip_d  = '0;
      fseen_d = 1'b0;
      ftag_d  = '0;
      ch_d    = '0;
      rate_d  = '0;
      bits_d  = '0;
      drem_d  = '0;
    end

    case (phase_d)
      wav_hdr_pkg::PH_RIFF: begin
        aw_d = {b, aw_d[31:8]};
        bc_d = bc_d + 5'd1;
        if (bc_d == 5'd4) begin
          tag_d = aw_d;
        end
        if (bc_d == 5'd12) begin
          if (tag_d != wav_hdr_pkg::TAG_RIFF || aw_d != wav_hdr_pkg::TAG_WAVE) begin
            err_v   = 1'b1;
            err_st  = wav_hdr_pkg::ST_BAD_TAGS;
            phase_d = wav_hdr_pkg::PH_HALT;
          end else begin
            phase_d = wav_hdr_pkg::PH_HDR;
            bc_d    = '0;
          end
        end
      end
      wav_hdr_pkg::PH_HDR: begin
        aw_d = {b, aw_d[31:8]};
        bc_d = bc_d + 5'd1;
        if (bc_d == 5'd4) begin
          tag_d = aw_d;
        end
        if (bc_d >= 5'd8) begin
          bc_d = '0;
          if (!fseen_d && tag_d == wav_hdr_pkg::TAG_FMT) begin
            fseen_d = 1'b1;
            if (aw_d < wav_hdr_pkg::FMT_MIN_SIZE) begin
              err_v   = 1'b1;
              err_st  = wav_hdr_pkg::ST_FMT_SHORT;
              phase_d = wav_hdr_pkg::PH_HALT;
            end else begin
              ftag_d  = '0;
              ch_d    = '0;
              rate_d  = '0;
              bits_d  = '0;
              phase_d = wav_hdr_pkg::PH_FMT;
            end
          end else if (fseen_d && tag_d == wav_hdr_pkg::TAG_DATA) begin
            if (check_format_i && (ch_d == 16'd0 || ch_d > 16'd2)) begin
              err_v   = 1'b1;
              err_st  = wav_hdr_pkg::ST_CHANNELS;
              phase_d = wav_hdr_pkg::PH_HALT;
            end else if (check_format_i && !wav_hdr_pkg::rate_ok(rate_d)) begin
              err_v   = 1'b1;
              err_st  = wav_hdr_pkg::ST_RATE;
              phase_d = wav_hdr_pkg::PH_HALT;
            end else if (check_format_i && bits_d != 16'd16 && bits_d != 16'd32) begin
              err_v   = 1'b1;
              err_st  = wav_hdr_pkg::ST_BITS;
              phase_d = wav_hdr_pkg::PH_HALT;
            end else begin
              norm_v                 = 1'b1;
              norm_rec.kind          = wav_hdr_pkg::KIND_FORMAT;
              norm_rec.status        = wav_hdr_pkg::ST_OK;
              norm_rec.rate_hz       = rate_d;
              norm_rec.channel_count = ch_d;
              norm_rec.sample_bits   = bits_d;
              norm_rec.payload_size  = aw_d;
              norm_rec.payload_byte  = '0;
              norm_rec.last          = (aw_d == '0);
              drem_d                 = aw_d;
              phase_d = (aw_d == '0) ? wav_hdr_pkg::PH_DONE : wav_hdr_pkg::PH_DATA;
            end
          end else begin
            cnt     = {1'b0, aw_d} + {32'd0, aw_d[0]};
            skip_d  = cnt;
            phase_d = (cnt == '0) ? wav_hdr_pkg::PH_HDR : wav_hdr_pkg::PH_SKIP;
          end
        end
      end
      wav_hdr_pkg::PH_FMT: begin
        p = bc_d[3:0];
        case (p)
          4'd0:    ftag_d[7:0]   = ftag_d[7:0] | b;
          4'd1:    ftag_d[15:8]  = ftag_d[15:8] | b;
          4'd2:    ch_d[7:0]     = ch_d[7:0] | b;
          4'd3:    ch_d[15:8]    = ch_d[15:8] | b;
          4'd4:    rate_d[7:0]   = rate_d[7:0] | b;
          4'd5:    rate_d[15:8]  = rate_d[15:8] | b;
          4'd6:    rate_d[23:16] = rate_d[23:16] | b;
          4'd7:    rate_d[31:24] = rate_d[31:24] | b;
          4'd14:   bits_d[7:0]   = bits_d[7:0] | b;
          4'd15:   bits_d[15:8]  = bits_d[15:8] | b;
          default: ;
        endcase
        bc_d = bc_d + 5'd1;
        if (bc_d >= 5'd16) begin
          if (ftag_d != wav_hdr_pkg::FMT_PCM) begin
            err_v   = 1'b1;
            err_st  = wav_hdr_pkg::ST_NOT_PCM;
            phase_d = wav_hdr_pkg::PH_HALT;
          end else begin
            cnt     = {1'b0, aw_d - wav_hdr_pkg::FMT_MIN_SIZE} + {32'd0, aw_d[0]};
            skip_d  = cnt;
            bc_d    = '0;
            phase_d = (cnt == '0) ? wav_hdr_pkg::PH_HDR : wav_hdr_pkg::PH_SKIP;
          end
        end
      end
      wav_hdr_pkg::PH_SKIP: begin
        if (skip_d != '0) begin
          skip_d = skip_d - 33'd1;
        end
        if (skip_d == '0) begin
          phase_d = wav_hdr_pkg::PH_HDR;
          bc_d    = '0;
        end
      end
      wav_hdr_pkg::PH_DATA: begin
        if (drem_d != '0) begin
          drem_d = drem_d - 32'd1;
        end
        norm_v                 = 1'b1;
        norm_rec.kind          = wav_hdr_pkg::KIND_DATA;
        norm_rec.status        = wav_hdr_pkg::ST_OK;
        norm_rec.rate_hz       = rate_d;
        norm_rec.channel_count = ch_d;
        norm_rec.sample_bits   = bits_d;
        norm_rec.payload_size  = aw_d;
        norm_rec.payload_byte  = b;
        norm_rec.last          = (drem_d == '0);
        if (drem_d == '0) begin
          phase_d = wav_hdr_pkg::PH_DONE;
        end
      end
      default: ;
    endcase

    if (item_i.file_end) begin
      case (phase_d)
        wav_hdr_pkg::PH_RIFF, wav_hdr_pkg::PH_FMT, wav_hdr_pkg::PH_DATA: begin
          err_v   = 1'b1;
          err_st  = wav_hdr_pkg::ST_TRUNCATED;
          phase_d = wav_hdr_pkg::PH_HALT;
        end
        wav_hdr_pkg::PH_HDR, wav_hdr_pkg::PH_SKIP: begin
          err_v   = 1'b1;
          err_st  = wav_hdr_pkg::ST_MISSING;
          phase_d = wav_hdr_pkg::PH_HALT;
        end
        default: ;
      endcase
    end

    err_rec        = '0;
    err_rec.kind   = wav_hdr_pkg::KIND_ERROR;
    err_rec.status = err_st;

    push_o.v0 = item_valid_i && (norm_v || err_v);
    push_o.v1 = item_valid_i && norm_v && err_v;
    rec0_o    = norm_v ? norm_rec : err_rec;
    rec1_o    = err_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= wav_hdr_pkg::PH_RIFF;
      bc_q    <= '0;
      aw_q    <= '0;
      tag_q   <= '0;
      skip_q  <= '0;
      fseen_q <= 1'b0;
      ftag_q  <= '0;
      ch_q    <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      drem_q  <= '0;
    end else if (item_valid_i) begin
      phase_q <= phase_d;
      bc_q    <= bc_d;
      aw_q    <= aw_d;
      tag_q   <= tag_d;
      skip_q  <= skip_d;
      fseen_q <= fseen_d;
      ftag_q  <= ftag_d;
      ch_q    <= ch_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      drem_q  <= drem_d;
    end
  end

endmodule

`default_nettype wire
